@@ design/mte_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mte_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);
	localparam int ID_W = 4;
	localparam int LAP_W = 8;
	localparam int DVS_W = LAP_W + 1;
	localparam int STEP_W = $clog2(LAP_W);

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_STOP = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_INIT = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

	localparam logic [1:0] CFG_ENABLE = 2'd0;
	localparam logic [1:0] CFG_TICK_RES = 2'd1;
	localparam logic [1:0] CFG_MAX_LAP = 2'd2;

	typedef struct packed {
		logic [1:0]       op;
		logic [7:0]       timer_id;
		logic [LAP_W-1:0] lap_ms;
		logic             single_shot;
	} item_t;

	typedef struct packed {
		logic            kind;
		logic [1:0]      status;
		logic [ID_W-1:0] fired_id;
		logic            last;
	} result_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [LAP_W-1:0] period;
		logic [7:0]       count;
		logic             single_shot;
	} entry_t;

endpackage

`default_nettype wire

@@ design/multi_timer_expiry_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

// start: dispatch, then (when enabled) the divider computes lap / resolution, then the reply
// stop: reply from dispatch; for a valid id, a read and a check per slot searched, then a tail move
// tick: on prescaler wrap, a read-modify-write of each active slot in table memory, then a flush
// results come from an output register one cycle each; the receiver cannot stall
// arst_n resets control, config, id flags, prescaler and entry count; table memory is not cleared
module multi_timer_expiry_table (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	output logic                    busy,
	input  wire mte_pkg::item_t     item,
	output logic                    result_strobe,
	output mte_pkg::result_t        result,
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire [1:0]               cfg_addr,
	input  wire [7:0]               cfg_data
);
	import mte_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_DIV    = 4'd2;
	localparam logic [3:0] S_SRD    = 4'd3;
	localparam logic [3:0] S_SCHK   = 4'd4;
	localparam logic [3:0] S_STAIL  = 4'd5;
	localparam logic [3:0] S_SMOVE  = 4'd6;
	localparam logic [3:0] S_TRD    = 4'd7;
	localparam logic [3:0] S_TCHK   = 4'd8;
	localparam logic [3:0] S_TTAIL  = 4'd9;
	localparam logic [3:0] S_TFLUSH = 4'd10;

	logic [3:0]          state_q, state_d;
	item_t               req_q;
	logic                en_q;
	logic [7:0]          tres_q;
	logic [7:0]          maxlap_q;
	logic [CNT_W-1:0]    active_q, active_d;
	logic [CNT_W-1:0]    idx_q, idx_d;
	logic [NUM_TIMERS:0] in_use_q, in_use_d;
	logic [7:0]          ps_q, ps_d;
	logic                pend_v_q, pend_v_d;
	logic [ID_W-1:0]     pend_id_q, pend_id_d;
	logic                res_v_q;
	result_t             res_q;
	logic                emit_v;
	result_t             emit_d;

	entry_t              mem [NUM_TIMERS];
	entry_t              rdata_q;
	logic                mem_we;
	logic [SLOT_W-1:0]   mem_waddr;
	entry_t              mem_wdata;
	logic [SLOT_W-1:0]   mem_raddr;

	logic                div_go;
	logic                div_done;
	logic [LAP_W-1:0]    div_quo;
	logic [LAP_W-1:0]    div_rem;

	logic                id_ok;
	logic                id_used;
	logic [7:0]          ps_inc;
	logic [7:0]          cnt_inc;
	logic                fire;
	logic                match;
	logic [CNT_W-1:0]    idx_inc;
	logic [CNT_W-1:0]    active_dec;
	logic                start_bad;

	mte_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (div_go),
		.dividend  (req_q.lap_ms),
		.divisor   ({tres_q == 8'd0, tres_q}),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign result_strobe = res_v_q;
	assign result = res_q;

	assign id_ok = (req_q.timer_id <= 8'(NUM_TIMERS));
	assign id_used = id_ok && in_use_q[req_q.timer_id[CNT_W-1:0]];
	assign ps_inc = ps_q + 8'd1;
	assign cnt_inc = rdata_q.count + 8'd1;
	assign fire = (cnt_inc == rdata_q.period);
	assign match = (rdata_q.id == req_q.timer_id[ID_W-1:0]);
	assign idx_inc = idx_q + CNT_W'(1);
	assign active_dec = active_q - CNT_W'(1);
	assign start_bad = !id_ok || id_used || (req_q.lap_ms > maxlap_q)
		|| (div_rem != '0) || (active_q >= CNT_W'(NUM_TIMERS));

	always_comb begin
		unique case (state_q) inside
			S_STAIL, S_TTAIL: mem_raddr = active_q[SLOT_W-1:0];
			default:          mem_raddr = idx_q[SLOT_W-1:0];
		endcase
	end

	always_comb begin
		state_d = state_q;
		active_d = active_q;
		idx_d = idx_q;
		in_use_d = in_use_q;
		ps_d = ps_q;
		pend_v_d = pend_v_q;
		pend_id_d = pend_id_q;
		emit_v = 1'b0;
		emit_d = '{kind: KIND_STATUS, status: ST_OK, fired_id: '0, last: 1'b1};
		mem_we = 1'b0;
		mem_waddr = idx_q[SLOT_W-1:0];
		mem_wdata = rdata_q;
		div_go = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (start)
					state_d = S_DISP;
			end
			S_DISP: begin
				state_d = S_IDLE;
				case (req_q.op)
					OP_START: begin
						if (!en_q) begin
							emit_v = 1'b1;
							emit_d.status = ST_NOT_INIT;
						end else begin
							div_go = 1'b1;
							state_d = S_DIV;
						end
					end
					OP_STOP: begin
						emit_v = 1'b1;
						if (!en_q) begin
							emit_d.status = ST_NOT_INIT;
						end else if (!id_used) begin
							emit_d.status = ST_INVALID;
						end else begin
							in_use_d[req_q.timer_id[CNT_W-1:0]] = 1'b0;
							idx_d = '0;
							state_d = S_SRD;
						end
					end
					OP_TICK: begin
						if (en_q) begin
							if (ps_inc == tres_q) begin
								ps_d = '0;
								if (active_q != '0) begin
									idx_d = '0;
									pend_v_d = 1'b0;
									state_d = S_TRD;
								end
							end else begin
								ps_d = ps_inc;
							end
						end
					end
					default: ;
				endcase
			end
			S_DIV: begin
				if (div_done) begin
					emit_v = 1'b1;
					state_d = S_IDLE;
					if (start_bad) begin
						emit_d.status = ST_INVALID;
					end else begin
						mem_we = 1'b1;
						mem_waddr = active_q[SLOT_W-1:0];
						mem_wdata = '{id: req_q.timer_id[ID_W-1:0], period: div_quo,
							count: 8'd0, single_shot: req_q.single_shot};
						active_d = active_q + CNT_W'(1);
						in_use_d[req_q.timer_id[CNT_W-1:0]] = 1'b1;
					end
				end
			end
			S_SRD: state_d = S_SCHK;
			S_SCHK: begin
				if (match) begin
					active_d = active_dec;
					state_d = (idx_q == active_dec) ? S_IDLE : S_STAIL;
				end else begin
					idx_d = idx_inc;
					state_d = (idx_inc >= active_q) ? S_IDLE : S_SRD;
				end
			end
			S_STAIL: state_d = S_SMOVE;
			S_SMOVE: begin
				mem_we = 1'b1;
				state_d = S_IDLE;
			end
			S_TRD: state_d = S_TCHK;
			S_TCHK: begin
				if (fire) begin
					if (pend_v_q) begin
						emit_v = 1'b1;
						emit_d = '{kind: KIND_EXPIRY, status: ST_OK, fired_id: pend_id_q,
							last: 1'b0};
					end
					pend_v_d = 1'b1;
					pend_id_d = rdata_q.id;
				end
				if (fire && rdata_q.single_shot) begin
					// slot freed: tail moves in and is handled in this same pass
					if (rdata_q.id <= ID_W'(NUM_TIMERS))
						in_use_d[rdata_q.id[CNT_W-1:0]] = 1'b0;
					active_d = active_dec;
					state_d = (idx_q >= active_dec) ? S_TFLUSH : S_TTAIL;
				end else begin
					mem_we = 1'b1;
					mem_wdata.count = fire ? 8'd0 : cnt_inc;
					idx_d = idx_inc;
					state_d = (idx_inc >= active_q) ? S_TFLUSH : S_TRD;
				end
			end
			S_TTAIL: state_d = S_TCHK;
			S_TFLUSH: begin
				if (pend_v_q) begin
					emit_v = 1'b1;
					emit_d = '{kind: KIND_EXPIRY, status: ST_OK, fired_id: pend_id_q,
						last: 1'b1};
				end
				pend_v_d = 1'b0;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			en_q <= 1'b0;
			tres_q <= 8'd1;
			maxlap_q <= 8'd255;
			active_q <= '0;
			idx_q <= '0;
			in_use_q <= '0;
			ps_q <= '0;
			pend_v_q <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			active_q <= active_d;
			idx_q <= idx_d;
			in_use_q <= in_use_d;
			ps_q <= ps_d;
			pend_v_q <= pend_v_d;
			res_v_q <= emit_v;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_addr)
					CFG_ENABLE:   en_q <= cfg_data[0];
					CFG_TICK_RES: tres_q <= cfg_data;
					CFG_MAX_LAP:  maxlap_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_id_q <= pend_id_d;
		if (emit_v)
			res_q <= emit_d;
		if (start && !busy)
			req_q <= item;
	end

	// table memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= CNT_W'(NUM_TIMERS))
		else $error("active entry count above table size");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside a start");

	a_transfer_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("input transfer did not make the block busy");

	a_expiry_id: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.kind == KIND_EXPIRY) |->
		(result.fired_id <= ID_W'(NUM_TIMERS) && result.status == ST_OK))
		else $error("expiry result with bad id or status");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DISP && req_q.op == OP_STOP) |=> (result_strobe && result.last))
		else $error("stop transfer without a final status reply");

endmodule

`default_nettype wire

@@ design/mte_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mte_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          go,
	input  wire [mte_pkg::LAP_W-1:0]     dividend,
	input  wire [mte_pkg::DVS_W-1:0]     divisor,
	output logic                         done,
	output logic [mte_pkg::LAP_W-1:0]    quotient,
	output logic [mte_pkg::LAP_W-1:0]    remainder
);
	import mte_pkg::*;

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [LAP_W-1:0]  rem_q;
	logic [LAP_W-1:0]  quo_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W-1:0]  trial;
	logic [DVS_W-1:0]  diff;
	logic              ge;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[LAP_W-1]};
	assign ge = (trial >= dvs_q);
	assign diff = trial - dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(LAP_W - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[LAP_W-1:0] : trial[LAP_W-1:0];
			quo_q <= {quo_q[LAP_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire
